// ===== rtl/drg_pkg.sv =====
// Shared types and constants of the dual Galois LFSR random generator.
// No dependencies; used by every module of the block.
package drg_pkg;

   localparam int LONG_W  = 32;
   localparam int SHORT_W = 31;
   localparam int WORD_W  = 32;

   // Reset values of the tap masks and the two shift registers
   localparam logic [LONG_W-1:0]  TAPS_LONG_RST  = 32'hB4BC_D35C;
   localparam logic [SHORT_W-1:0] TAPS_SHORT_RST = 31'h7A5B_C2E3;
   localparam logic [LONG_W-1:0]  LONG_RST       = 32'hDEAD_BEEF;
   localparam logic [SHORT_W-1:0] SHORT_RST      = 31'h2345_6789;

   // Configuration register indexes
   localparam logic CSR_TAPS_LONG  = 1'b0;
   localparam logic CSR_TAPS_SHORT = 1'b1;

   // Request opcodes; the fourth code is unused and ignored
   typedef enum logic [1:0] {
      OP_SEED  = 2'd0,
      OP_DRAW  = 2'd1,
      OP_RANGE = 2'd2
   } op_type;

   // Control of the LFSR pair
   typedef struct packed {
      logic              load;
      logic              advance;
      logic [WORD_W-1:0] seed;
   } lfsr_ctl_type;

   // Start of a remainder computation
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } rem_req_type;

   // Remainder result, valid for one cycle with done
   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] remainder;
   } rem_rsp_type;

endpackage

// ===== rtl/drg_lfsr.sv =====
// Tap mask registers and the pair of right-shifting Galois LFSRs.
// Depends on drg_pkg.
module drg_lfsr import drg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [WORD_W-1:0]  csr_data,
   input  lfsr_ctl_type       ctl,
   output logic [WORD_W-1:0]  mix
);

   logic [LONG_W-1:0]  taps_long_ff;
   logic [SHORT_W-1:0] taps_short_ff;
   logic [LONG_W-1:0]  long_ff;
   logic [LONG_W-1:0]  long_in;
   logic [LONG_W-1:0]  long_half;
   logic [SHORT_W-1:0] short_ff;
   logic [SHORT_W-1:0] short_in;

   // Shift the long register twice and the short register once
   always_comb begin
      long_half = (long_ff >> 1) ^ (long_ff[0] ? taps_long_ff : '0);
      long_in   = (long_half >> 1) ^ (long_half[0] ? taps_long_ff : '0);
      short_in  = (short_ff >> 1) ^ (short_ff[0] ? taps_short_ff : '0);
   end

   // Combine the two registers into the output word
   assign mix = long_ff ^ {1'b0, short_ff};

   // Hold taps and state; load on seed, advance on draw
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_long_ff  <= TAPS_LONG_RST;
         taps_short_ff <= TAPS_SHORT_RST;
         long_ff       <= LONG_RST;
         short_ff      <= SHORT_RST;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_TAPS_LONG) begin
               taps_long_ff <= csr_data;
            end else begin
               taps_short_ff <= csr_data[SHORT_W-1:0];
            end
         end
         if (ctl.load) begin
            long_ff  <= ctl.seed;
            short_ff <= ctl.seed[WORD_W-1:1];
         end else if (ctl.advance) begin
            long_ff  <= long_in;
            short_ff <= short_in;
         end
      end
   end

endmodule

// ===== rtl/drg_rem.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
// Depends on drg_pkg.
module drg_rem import drg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rem_req_type req,
   output rem_rsp_type rsp
);

   localparam int CNT_W = $clog2(WORD_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [WORD_W-1:0]   dividend_ff;
   logic [WORD_W-1:0]   divisor_ff;
   logic [WORD_W-1:0]   rem_ff;
   logic [WORD_W-1:0]   rem_in;
   logic [WORD_W:0]     shifted;
   logic [WORD_W:0]     diff;
   logic                fits;

   // Bring down the next dividend bit and try one subtract
   always_comb begin
      shifted = {rem_ff, dividend_ff[WORD_W-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};
      rem_in  = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
   end

   // Step the sequence: start, iterate over all bits, pulse done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(WORD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req.start) begin
         dividend_ff <= req.dividend;
         divisor_ff  <= req.divisor;
         rem_ff      <= '0;
      end else if (busy_ff) begin
         dividend_ff <= {dividend_ff[WORD_W-2:0], 1'b0};
         rem_ff      <= rem_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

   // A finished remainder is below the divisor
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < divisor_ff)
      else $error("remainder not below divisor");

   // No restart while iterating
   assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("remainder unit started while busy");

   // Done follows only the last iteration
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a finished iteration");

endmodule

// ===== rtl/dual_lfsr_random_generator_top.sv =====
// Top level of the dual Galois LFSR random generator: sequencer and output register.
// Depends on drg_pkg, drg_lfsr and drg_rem.
//
// A seed request loads the LFSR pair and gives no response. A plain draw
// passes through the draw and output states into the output register. A
// bounded draw with a nonzero span also waits in the divide state, where
// the remainder unit resolves one dividend bit per cycle. The request side stalls
// during reset and while a draw is in progress, and is free again once the
// result has moved into the output register, so a new request is taken while
// the response still waits for the consumer. Tap masks are written through
// the csr port, which is ready whenever reset is low; write them only while
// the block is idle.
module dual_lfsr_random_generator_top import drg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [WORD_W-1:0]  req_seed_value,
   input  logic [WORD_W-1:0]  req_low_bound,
   input  logic [WORD_W-1:0]  req_high_bound,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [WORD_W-1:0]  rsp_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [WORD_W-1:0]  csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DRAW,
      S_DIV,
      S_OUT
   } state_type;

   state_type          state_ff;
   logic               range_ff;
   logic [WORD_W-1:0]  low_ff;
   logic [WORD_W-1:0]  span_ff;
   logic [WORD_W-1:0]  result_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_value_ff;
   logic               req_xfer;
   logic               out_free;
   logic [WORD_W-1:0]  mix;
   lfsr_ctl_type       lfsr_ctl;
   rem_req_type        rem_req;
   rem_rsp_type        rem_rsp;

   assign req_stall = reset || state_ff != S_IDLE;
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // Drive the LFSR pair from the accepted request
   always_comb begin
      lfsr_ctl      = '0;
      lfsr_ctl.seed = req_seed_value;
      if (req_xfer) begin
         case (req_op)
            OP_SEED: lfsr_ctl.load = 1'b1;
            OP_DRAW, OP_RANGE: lfsr_ctl.advance = 1'b1;
            default: lfsr_ctl.load = 1'b0;
         endcase
      end
   end

   // Start the remainder unit for a bounded draw with a nonzero span
   always_comb begin
      rem_req.start    = state_ff == S_DRAW && range_ff && span_ff != '0;
      rem_req.dividend = mix;
      rem_req.divisor  = span_ff;
   end

   drg_lfsr u_lfsr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (lfsr_ctl),
      .mix       (mix)
   );

   drg_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   // Sequencer state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load the output register when it frees; drop valid after its transfer
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= result_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer && (req_op == OP_DRAW || req_op == OP_RANGE)) begin
                  state_ff <= S_DRAW;
               end
            end
            S_DRAW: begin
               state_ff <= rem_req.start ? S_DIV : S_OUT;
            end
            S_DIV: begin
               if (rem_rsp.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Capture operands and results
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         range_ff <= req_op == OP_RANGE;
         low_ff   <= req_low_bound;
         span_ff  <= req_high_bound + 32'd1 - req_low_bound;
      end
      if (state_ff == S_DRAW) begin
         result_ff <= mix;
      end
      if (state_ff == S_DIV && rem_rsp.done) begin
         result_ff <= rem_rsp.remainder + low_ff;
      end
   end

   // Remainder results arrive only while waiting on them
   assert property (@(posedge clock) disable iff (reset)
      rem_rsp.done |-> state_ff == S_DIV)
      else $error("remainder done outside divide state");

   // A draw transfer enters the draw state next
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_op == OP_DRAW || req_op == OP_RANGE) |=> state_ff == S_DRAW)
      else $error("draw transfer did not start a draw");

   // A blocked result holds until the output register frees
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && !out_free |=> state_ff == S_OUT && $stable(result_ff))
      else $error("pending result lost");

endmodule
